>>> src/cdq_pkg.sv
// shared codes and types for the circular deque
`default_nettype none
package cdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NOP        = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

endpackage
`default_nettype wire

>>> src/cdq_ifs.sv
// item channels of the circular deque
`default_nettype none
interface cdq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cdq_out_if #(
  parameter int unsigned CW = 4
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic               is_empty;
  logic [CW-1:0]      fill_count;

  modport source (output valid, output status, output popped_value, output front_value,
                  output rear_value, output is_empty, output fill_count, input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input rear_value, input is_empty, input fill_count, output ready);
endinterface
`default_nettype wire

>>> src/cdq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/circular_deque.sv
// circular deque: top level with ring controller
// A double-ended queue of 32-bit words held in a ring ram of DEPTH entries. Each input item
// carries one action (push front, push back, pop front, pop back, no operation) and gives one
// result item with the status, the popped word, the front and rear words, an empty flag and
// the fill count after the action. A push on a full queue or a pop on an empty one is refused
// and changes nothing. The front and rear words are kept in registers beside the ram, so most
// actions go from acceptance straight to the send state and load the output register there;
// a pop that leaves two or more words behind must first fetch the new end word from the ram
// through its registered read port in the fetch state. The send state waits while the output
// register still holds a result that has not been taken.
// One item is in work at a time; the next one is accepted while the previous result still
// waits in the output register.
`default_nettype none
module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);
  localparam logic [CW-1:0] TWO_CNT  = CW'(2);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [WORD_W-1:0]   front_r, front_nxt;
  logic [WORD_W-1:0]   rear_r, rear_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic [WORD_W-1:0]   popped_r, popped_nxt;
  logic                fetch_front_r, fetch_front_nxt;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [WORD_W-1:0]   out_popped_r;
  logic [WORD_W-1:0]   out_front_r;
  logic [WORD_W-1:0]   out_rear_r;
  logic                out_empty_r;
  logic [CW-1:0]       out_count_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                accept;
  logic                load_out;
  logic [AW-1:0]       head_up, head_dn, tail_up, tail_dn;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
    step_up = (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
    step_down = (idx == '0) ? LAST_IDX : idx - AW'(1);
  endfunction

  assign head_up = step_up(head_r);
  assign head_dn = step_down(head_r);
  assign tail_up = step_up(tail_r);
  assign tail_dn = step_down(tail_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_SEND) && (!out_valid_r || out_ch.ready);

  // reads and writes never share a cycle, so the ram needs no forwarding
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    stat_nxt        = stat_r;
    popped_nxt      = popped_r;
    fetch_front_nxt = fetch_front_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = in_ch.push_value;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          stat_nxt   = ST_DONE;
          popped_nxt = '0;
          state_nxt  = S_SEND;
          case (in_ch.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (count_r >= FULL_CNT) begin
                stat_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + ONE_CNT;
                if (count_r == '0) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  ram_waddr = '0;
                  front_nxt = in_ch.push_value;
                  rear_nxt  = in_ch.push_value;
                end else if (in_ch.action == ACT_PUSH_FRONT) begin
                  head_nxt  = head_dn;
                  ram_waddr = head_dn;
                  front_nxt = in_ch.push_value;
                end else begin
                  tail_nxt  = tail_up;
                  ram_waddr = tail_up;
                  rear_nxt  = in_ch.push_value;
                end
              end
            end
            ACT_POP_FRONT: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                popped_nxt = front_r;
                count_nxt  = count_r - ONE_CNT;
                if (count_r == ONE_CNT) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else if (count_r == TWO_CNT) begin
                  head_nxt  = head_up;
                  front_nxt = rear_r;
                end else begin
                  head_nxt        = head_up;
                  ram_re          = 1'b1;
                  ram_raddr       = head_up;
                  fetch_front_nxt = 1'b1;
                  state_nxt       = S_FETCH;
                end
              end
            end
            ACT_POP_BACK: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                popped_nxt = rear_r;
                count_nxt  = count_r - ONE_CNT;
                if (count_r == ONE_CNT) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else if (count_r == TWO_CNT) begin
                  tail_nxt = tail_dn;
                  rear_nxt = front_r;
                end else begin
                  tail_nxt        = tail_dn;
                  ram_re          = 1'b1;
                  ram_raddr       = tail_dn;
                  fetch_front_nxt = 1'b0;
                  state_nxt       = S_FETCH;
                end
              end
            end
            default: begin
              // no operation, unused codes included
            end
          endcase
        end
      end
      S_FETCH: begin
        if (fetch_front_r) begin
          front_nxt = ram_rdata;
        end else begin
          rear_nxt = ram_rdata;
        end
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r       <= front_nxt;
    rear_r        <= rear_nxt;
    stat_r        <= stat_nxt;
    popped_r      <= popped_nxt;
    fetch_front_r <= fetch_front_nxt;
    if (load_out) begin
      out_status_r <= stat_r;
      out_popped_r <= popped_r;
      out_front_r  <= (count_r == '0) ? '0 : front_r;
      out_rear_r   <= (count_r == '0) ? '0 : rear_r;
      out_empty_r  <= (count_r == '0);
      out_count_r  <= count_r;
    end
  end

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.front_value  = out_front_r;
  assign out_ch.rear_value   = out_rear_r;
  assign out_ch.is_empty     = out_empty_r;
  assign out_ch.fill_count   = out_count_r;

endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the circular deque: queued stimulus, clocked driver and monitor
`default_nettype none
module testbench;
  import cdq_pkg::*;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned RAND_OPS  = 2000;
  localparam int unsigned MAX_PRINT = 20;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] push_value;
    int unsigned              idle_pct;
    int unsigned              stall_pct;
    bit                       drain_first;
  } deque_op_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic [CNT_W-1:0]         fill_count;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cdq_in_if               in_ch ();
  cdq_out_if #(.CW(CNT_W)) out_ch ();

  circular_deque #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  logic [2:0]               front_idx;
  logic [2:0]               back_idx;
  logic [CNT_W-1:0]         words_held;

  deque_op_t     pending_ops [$];
  deque_result_t expected_results [$];
  deque_op_t     drv_item;
  deque_result_t got_item;
  deque_result_t want_item;

  int unsigned stall_pct_now;
  int unsigned err_count;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned full_refusals;
  int unsigned empty_refusals;
  int unsigned max_fill_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [2:0] ring_next(input logic [2:0] idx);
    return (idx == 3'(DEPTH - 1)) ? 3'd0 : idx + 3'd1;
  endfunction

  function automatic logic [2:0] ring_prev(input logic [2:0] idx);
    return (idx == 3'd0) ? 3'(DEPTH - 1) : idx - 3'd1;
  endfunction

  // applies one action to the model deque and gives the result item it should cause
  function automatic deque_result_t apply_action(input logic [ACT_W-1:0] act,
                                                 input logic signed [WORD_W-1:0] word);
    deque_result_t r;
    r.status       = ST_DONE;
    r.popped_value = '0;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (words_held >= CNT_W'(DEPTH)) begin
        r.status = ST_FULL;
        full_refusals++;
      end else begin
        if (words_held == '0) begin
          front_idx     = 3'd0;
          back_idx      = 3'd0;
          ring_words[0] = word;
        end else if (act == ACT_PUSH_FRONT) begin
          front_idx             = ring_prev(front_idx);
          ring_words[front_idx] = word;
        end else begin
          back_idx             = ring_next(back_idx);
          ring_words[back_idx] = word;
        end
        words_held++;
      end
    end else if (act == ACT_POP_FRONT || act == ACT_POP_BACK) begin
      if (words_held == '0) begin
        r.status = ST_EMPTY;
        empty_refusals++;
      end else begin
        if (act == ACT_POP_FRONT) begin
          r.popped_value = ring_words[front_idx];
          front_idx      = ring_next(front_idx);
        end else begin
          r.popped_value = ring_words[back_idx];
          back_idx       = ring_prev(back_idx);
        end
        words_held--;
        if (words_held == '0) begin
          front_idx = 3'd0;
          back_idx  = 3'd0;
        end
      end
    end
    // anything else, unused codes included, leaves the deque as it is
    r.is_empty    = (words_held == '0);
    r.front_value = r.is_empty ? '0 : ring_words[front_idx];
    r.rear_value  = r.is_empty ? '0 : ring_words[back_idx];
    r.fill_count  = words_held;
    if (words_held > max_fill_seen) max_fill_seen = words_held;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINT)
      $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic add_op(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] word,
                        input int unsigned idle, input int unsigned stall, input bit drain);
    deque_op_t op;
    op.action      = act;
    op.push_value  = word;
    op.idle_pct    = idle;
    op.stall_pct   = stall;
    op.drain_first = drain;
    pending_ops.push_back(op);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // driver: the next item goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= ACT_NOP;
      in_ch.push_value <= '0;
      stall_pct_now    <= 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_action(in_ch.action, in_ch.push_value));
        items_accepted++;
      end
      if (pending_ops.size() != 0 &&
          !(pending_ops[0].drain_first && expected_results.size() != 0) &&
          $urandom_range(99) >= pending_ops[0].idle_pct) begin
        drv_item          = pending_ops.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.action     <= drv_item.action;
        in_ch.push_value <= drv_item.push_value;
        stall_pct_now    <= drv_item.stall_pct;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got_item.status       = out_ch.status;
        got_item.popped_value = out_ch.popped_value;
        got_item.front_value  = out_ch.front_value;
        got_item.rear_value   = out_ch.rear_value;
        got_item.is_empty     = out_ch.is_empty;
        got_item.fill_count   = out_ch.fill_count;
        if (expected_results.size() == 0) begin
          report_mismatch("result item with none expected", 32'(got_item.status), '0);
        end else begin
          want_item = expected_results.pop_front();
          if (got_item.status !== want_item.status)
            report_mismatch("status", 32'(got_item.status), 32'(want_item.status));
          if (got_item.popped_value !== want_item.popped_value)
            report_mismatch("popped_value", got_item.popped_value, want_item.popped_value);
          if (got_item.front_value !== want_item.front_value)
            report_mismatch("front_value", got_item.front_value, want_item.front_value);
          if (got_item.rear_value !== want_item.rear_value)
            report_mismatch("rear_value", got_item.rear_value, want_item.rear_value);
          if (got_item.is_empty !== want_item.is_empty)
            report_mismatch("is_empty", 32'(got_item.is_empty), 32'(want_item.is_empty));
          if (got_item.fill_count !== want_item.fill_count)
            report_mismatch("fill_count", 32'(got_item.fill_count),
                            32'(want_item.fill_count));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct_now);
    end
  end

  initial begin
    int unsigned phase;
    int unsigned idle;
    int unsigned stall;
    int unsigned made;
    int unsigned seg_len;
    int unsigned push_bias;
    int unsigned roll;
    int unsigned wait_cycles;
    logic [ACT_W-1:0] act;
    bit drain;

    err_count        = 0;
    items_accepted   = 0;
    results_seen     = 0;
    full_refusals    = 0;
    empty_refusals   = 0;
    max_fill_seen    = 0;
    front_idx        = 3'd0;
    back_idx         = 3'd0;
    words_held       = '0;
    for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
    rst_n = 1'b0;

    // directed part: refusals on empty, unused codes, first push, fill to full, refusals on full, pops
    add_op(ACT_POP_FRONT, 32'sh1234_5678, 0, 0, 1'b0);
    add_op(ACT_POP_BACK, -32'sd1, 0, 0, 1'b0);
    add_op(ACT_NOP, 32'sh7fff_ffff, 0, 0, 1'b0);
    add_op(3'd5, 32'sh8000_0000, 0, 0, 1'b0);
    add_op(3'd6, '0, 0, 0, 1'b0);
    add_op(3'd7, -32'sd1, 0, 0, 1'b0);
    add_op(ACT_PUSH_FRONT, 32'sh7fff_ffff, 0, 0, 1'b0);
    add_op(ACT_POP_BACK, '0, 0, 0, 1'b0);
    add_op(ACT_PUSH_BACK, 32'sh8000_0000, 0, 0, 1'b0);
    add_op(ACT_PUSH_FRONT, -32'sd1, 0, 0, 1'b0);
    add_op(ACT_PUSH_BACK, '0, 0, 0, 1'b0);
    add_op(ACT_PUSH_FRONT, 32'sh0000_0001, 0, 0, 1'b0);
    for (int i = 0; i < 4; i++)
      add_op(ACT_PUSH_BACK, 32'sh5a5a_0000 + i, 0, 0, 1'b0);
    add_op(ACT_PUSH_FRONT, 32'sh0bad_0001, 0, 0, 1'b0);
    add_op(ACT_PUSH_BACK, 32'sh0bad_0002, 0, 0, 1'b0);
    add_op(ACT_POP_FRONT, '0, 0, 0, 1'b0);
    add_op(ACT_POP_BACK, '0, 0, 0, 1'b0);
    add_op(ACT_NOP, '0, 0, 0, 1'b0);
    add_op(ACT_PUSH_FRONT, 32'sh0000_cafe, 0, 0, 1'b0);

    // random part in four flow phases; runs of push-heavy or pop-heavy actions
    // walk the fill level between empty and full many times
    made = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle = 0;  stall = 0;  end
        1: begin idle = 78; stall = 0;  end
        2: begin idle = 0;  stall = 78; end
        default: begin idle = 12; stall = 12; end
      endcase
      drain = 1'b1;
      while (made < (phase + 1) * (RAND_OPS / 4)) begin
        seg_len   = $urandom_range(4, 24);
        push_bias = $urandom_range(1) ? 75 : 25;
        for (int k = 0; k < seg_len; k++) begin
          roll = $urandom_range(99);
          if (roll < 4)
            act = 3'($urandom_range(4, 7));
          else if ($urandom_range(99) < push_bias)
            act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
          else
            act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
          if ($urandom_range(99) == 0) drain = 1'b1;
          add_op(act, pick_word(), idle, stall, drain);
          drain = 1'b0;
          made++;
        end
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    // a stray extra result would show up in the monitor within this window
    wait_cycles = 10;
    repeat (wait_cycles) @(posedge clk);

    $display("%0d items sent, %0d results checked; %0d refused as full, %0d as empty",
             items_accepted, results_seen, full_refusals, empty_refusals);
    $display("fill level reached %0d of %0d; four flow phases with drained pauses",
             max_fill_seen, DEPTH);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("run did not finish in time, %0d results still expected",
             expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

>>> circular_deque.f
src/cdq_pkg.sv
src/cdq_ifs.sv
src/cdq_ram.sv
src/circular_deque.sv
dv/testbench.sv
